// ===== rtl/core/tpd_pkg.sv =====
// Touch packet decoder package: widths, register reset values, register
// index codes and the shared configuration and frame structs.
// No dependencies.
`timescale 1ns / 1ps

package tpd_pkg;

    localparam int COORD_BITS    = 12;
    localparam int LOW_BITS      = 7;
    localparam int HIGH_BITS     = COORD_BITS - LOW_BITS;
    localparam int GAIN_BITS     = 16;
    localparam int BYTE_BITS     = 8;
    localparam int CFG_DATA_BITS = (GAIN_BITS > COORD_BITS) ? GAIN_BITS : COORD_BITS;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [BYTE_BITS-1:0] HDR_DOWN = 8'h81;
    localparam logic [BYTE_BITS-1:0] HDR_UP   = 8'h80;

    localparam logic [COORD_BITS-1:0] X_OFFSET_RST = COORD_BITS'(108);
    localparam logic [COORD_BITS-1:0] Y_OFFSET_RST = COORD_BITS'(260);
    localparam logic [GAIN_BITS-1:0]  X_GAIN_RST   = GAIN_BITS'(13378);
    localparam logic [GAIN_BITS-1:0]  Y_GAIN_RST   = GAIN_BITS'(8357);
    localparam logic [COORD_BITS-1:0] X_LIMIT_RST  = COORD_BITS'(800);
    localparam logic [COORD_BITS-1:0] Y_LIMIT_RST  = COORD_BITS'(480);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_X_OFFSET = 3'd0,
        REG_Y_OFFSET = 3'd1,
        REG_X_GAIN   = 3'd2,
        REG_Y_GAIN   = 3'd3,
        REG_X_LIMIT  = 3'd4,
        REG_Y_LIMIT  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x_offset;
        logic [COORD_BITS-1:0] y_offset;
        logic [GAIN_BITS-1:0]  x_gain;
        logic [GAIN_BITS-1:0]  y_gain;
        logic [COORD_BITS-1:0] x_limit;
        logic [COORD_BITS-1:0] y_limit;
    } cfg_t;

    typedef struct packed {
        logic                  pen;
        logic [COORD_BITS-1:0] x_raw;
        logic [COORD_BITS-1:0] y_raw;
    } frame_t;

endpackage

// ===== rtl/core/tpd_cfg_regs.sv =====
// Calibration register file of the touch packet decoder.
// Depends on tpd_pkg.
`timescale 1ns / 1ps

module tpd_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tpd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tpd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output tpd_pkg::cfg_t                      cfg
);
    import tpd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_X_OFFSET: cfg_next.x_offset = cfg_data[COORD_BITS-1:0];
                REG_Y_OFFSET: cfg_next.y_offset = cfg_data[COORD_BITS-1:0];
                REG_X_GAIN:   cfg_next.x_gain   = cfg_data[GAIN_BITS-1:0];
                REG_Y_GAIN:   cfg_next.y_gain   = cfg_data[GAIN_BITS-1:0];
                REG_X_LIMIT:  cfg_next.x_limit  = cfg_data[COORD_BITS-1:0];
                REG_Y_LIMIT:  cfg_next.y_limit  = cfg_data[COORD_BITS-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_offset <= X_OFFSET_RST;
            cfg_reg.y_offset <= Y_OFFSET_RST;
            cfg_reg.x_gain   <= X_GAIN_RST;
            cfg_reg.y_gain   <= Y_GAIN_RST;
            cfg_reg.x_limit  <= X_LIMIT_RST;
            cfg_reg.y_limit  <= Y_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/tpd_framer.sv =====
// Byte framer: tracks the five-byte packet and holds the assembled raw
// coordinates until the scaler takes them. Depends on tpd_pkg.
`timescale 1ns / 1ps

module tpd_framer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic [tpd_pkg::BYTE_BITS-1:0]  rx_byte,
    input  logic                           advance,
    output logic                           frame_valid,
    output tpd_pkg::frame_t                frame
);
    import tpd_pkg::*;

    typedef enum logic [2:0] {
        WAIT_HDR,
        X_LOW,
        X_HIGH,
        Y_LOW,
        Y_HIGH
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic                   pen_reg, pen_next;
    logic [LOW_BITS-1:0]    x_low_reg, x_low_next;
    logic [HIGH_BITS-1:0]   x_high_reg, x_high_next;
    logic [LOW_BITS-1:0]    y_low_reg, y_low_next;
    logic                   frame_valid_reg, frame_valid_next;
    frame_t                 frame_reg, frame_next;
    logic [HIGH_BITS-1:0]   byte_high;

    assign byte_high = HIGH_BITS'(rx_byte[LOW_BITS-1:0]);

    always_comb
    begin
        phase_next       = phase_reg;
        pen_next         = pen_reg;
        x_low_next       = x_low_reg;
        x_high_next      = x_high_reg;
        y_low_next       = y_low_reg;
        frame_next       = frame_reg;
        frame_valid_next = frame_valid_reg && !advance;

        if (accept)
        begin
            if (rx_byte[BYTE_BITS-1])
            begin
                // any marked byte restarts framing; only headers open a frame
                if (rx_byte == HDR_DOWN || rx_byte == HDR_UP)
                begin
                    pen_next   = rx_byte[0];
                    phase_next = X_LOW;
                end
                else
                begin
                    phase_next = WAIT_HDR;
                end
            end
            else
            begin
                unique case (phase_reg)
                    X_LOW:
                    begin
                        x_low_next = rx_byte[LOW_BITS-1:0];
                        phase_next = X_HIGH;
                    end
                    X_HIGH:
                    begin
                        x_high_next = byte_high;
                        phase_next  = Y_LOW;
                    end
                    Y_LOW:
                    begin
                        y_low_next = rx_byte[LOW_BITS-1:0];
                        phase_next = Y_HIGH;
                    end
                    Y_HIGH:
                    begin
                        frame_next.pen   = pen_reg;
                        frame_next.x_raw = {x_high_reg, x_low_reg};
                        frame_next.y_raw = {byte_high, y_low_reg};
                        frame_valid_next = 1'b1;
                        phase_next       = WAIT_HDR;
                    end
                    default: phase_next = WAIT_HDR;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= WAIT_HDR;
            pen_reg         <= 1'b0;
            x_low_reg       <= '0;
            x_high_reg      <= '0;
            y_low_reg       <= '0;
            frame_valid_reg <= 1'b0;
            frame_reg       <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            pen_reg         <= pen_next;
            x_low_reg       <= x_low_next;
            x_high_reg      <= x_high_next;
            y_low_reg       <= y_low_next;
            frame_valid_reg <= frame_valid_next;
            frame_reg       <= frame_next;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

// ===== rtl/core/tpd_scaler.sv =====
// Calibration scaler and result register: offset, Q0.16 gain, clamp.
// Depends on tpd_pkg.
`timescale 1ns / 1ps

module tpd_scaler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tpd_pkg::cfg_t                   cfg,
    input  logic                            frame_valid,
    input  tpd_pkg::frame_t                 frame,
    output logic                            advance,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            pen_down,
    output logic [tpd_pkg::COORD_BITS-1:0]  x_pixel,
    output logic [tpd_pkg::COORD_BITS-1:0]  y_pixel
);
    import tpd_pkg::*;

    localparam int PROD_BITS = COORD_BITS + GAIN_BITS;

    function automatic logic [COORD_BITS-1:0] scale_axis(
        input logic [COORD_BITS-1:0] raw,
        input logic [COORD_BITS-1:0] offset,
        input logic [GAIN_BITS-1:0]  gain,
        input logic [COORD_BITS-1:0] limit
    );
        logic [COORD_BITS:0]   diff;
        logic [PROD_BITS-1:0]  prod;
        logic [COORD_BITS-1:0] scaled;
        diff   = {1'b0, raw} - {1'b0, offset};
        prod   = PROD_BITS'(diff[COORD_BITS-1:0]) * PROD_BITS'(gain);
        scaled = prod[PROD_BITS-1:GAIN_BITS];
        // raw below offset borrows out: clamp low
        if (diff[COORD_BITS])
            return '0;
        else if (scaled > limit)
            return limit;
        else
            return scaled;
    endfunction

    logic                  out_valid_reg, out_valid_next;
    logic                  pen_reg, pen_next;
    logic [COORD_BITS-1:0] x_reg, x_next;
    logic [COORD_BITS-1:0] y_reg, y_next;

    assign advance = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pen_next       = pen_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        if (advance)
        begin
            out_valid_next = frame_valid;
            if (frame_valid)
            begin
                pen_next = frame.pen;
                x_next   = scale_axis(frame.x_raw, cfg.x_offset, cfg.x_gain, cfg.x_limit);
                y_next   = scale_axis(frame.y_raw, cfg.y_offset, cfg.y_gain, cfg.y_limit);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pen_reg <= pen_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign out_valid = out_valid_reg;
    assign pen_down  = pen_reg;
    assign x_pixel   = x_reg;
    assign y_pixel   = y_reg;

endmodule

// ===== rtl/core/touch_packet_decoder_unit.sv =====
// Touch packet decoder top level: config registers, byte framer, scaler.
// Depends on tpd_pkg, tpd_cfg_regs, tpd_framer and tpd_scaler.
//
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) takes one received byte
//   per request. A 0x81 or 0x80 header opens a packet; four data bytes
//   follow. Other bytes with bit 7 set drop the partial packet, and data
//   bytes outside a packet are dropped.
//   Output channel (out_valid / out_stall) carries pen_down, x_pixel and
//   y_pixel, one request per complete packet.
//   Throughput: one byte per cycle while in_stall is low. The fourth data
//   byte loads the framer register; the result register, behind the offset,
//   gain multiply and clamp, then takes the frame and presents the result.
//   Stalls: a finished frame waits in the framer register while the result
//   register is stalled. Bytes keep flowing in while the framer register is
//   empty; in_stall rises when a frame is waiting and the result register
//   cannot take it, and then holds every byte, headers included.
//   Reset: framing returns to waiting for a header, no result is pending, and
//   the calibration registers return to their defaults. Config: cfg_we writes
//   cfg_data to register cfg_index; users write only while idle (unchecked).
`timescale 1ns / 1ps

module touch_packet_decoder_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tpd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tpd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [tpd_pkg::BYTE_BITS-1:0]      rx_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               pen_down,
    output logic [tpd_pkg::COORD_BITS-1:0]     x_pixel,
    output logic [tpd_pkg::COORD_BITS-1:0]     y_pixel
);
    import tpd_pkg::*;

    cfg_t   cfg;
    frame_t frame;
    logic   frame_valid;
    logic   advance;
    logic   accept;

    // hold input only when a finished frame cannot move on
    assign in_stall = frame_valid && !advance;
    assign accept   = in_valid && !in_stall;

    tpd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpd_framer u_framer (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .advance     (advance),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    tpd_scaler u_scaler (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .frame_valid (frame_valid),
        .frame       (frame),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pen_down    (pen_down),
        .x_pixel     (x_pixel),
        .y_pixel     (y_pixel)
    );

    a_stall_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> frame_valid)
        else $error("input stalled with no frame waiting");

    a_frame_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && advance) |=> out_valid)
        else $error("frame advanced but no result presented");

    a_marked_byte_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rx_byte[BYTE_BITS-1]) |=> !frame_valid)
        else $error("marked byte produced a frame");

endmodule
